FILE: rtl/core/yuv420_to_rgb888_convert_defines.svh
// Assertion macros used by the checker of this block.
`ifndef YUV420_TO_RGB888_CONVERT_DEFINES_SVH
`define YUV420_TO_RGB888_CONVERT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define Y2R_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define Y2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/y2r_pkg.sv
`default_nettype none

package y2r_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = COL_W - 1;
    localparam int FW_W       = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST = FW_W'(1920);
    localparam logic [FW_W-1:0] MAX_WIDTH_FW    = FW_W'(MAX_WIDTH);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_ORDER = CFG_IDX_W'(1);

    typedef logic signed [19:0] t_acc;

    localparam t_acc K_Y     = 20'sd298;
    localparam t_acc K_RV    = 20'sd409;
    localparam t_acc K_GU    = 20'sd100;
    localparam t_acc K_GV    = 20'sd208;
    localparam t_acc K_BU    = 20'sd516;
    localparam t_acc K_ROUND = 20'sd128;

    localparam logic [8:0] LUMA_BIAS = 9'd16;
    localparam logic [8:0] C_OFFSET  = 9'd128;

    function automatic logic [7:0] clip_shift(input t_acc x);
        logic signed [11:0] s;
        logic [7:0] r;
        s = x[19:8];
        if (s < 12'sd0) begin
            r = 8'd0;
        end else if (s > 12'sd255) begin
            r = 8'd255;
        end else begin
            r = s[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/y2r_ram.sv
`default_nettype none

module y2r_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/yuv420_to_rgb888_convert.sv
`default_nettype none

// BT.601 limited-range YUV 4:2:0 to RGB888 converter. It takes one luma sample per clock
// in raster order and gives one RGB pixel per clock, both unless the output side stalls;
// each pixel passes an input register and then an output register before it is offered.
// The chroma line buffer has one write and one read port and is either written or read
// once per pixel, so it never holds up the stream. The chroma pair carried on even rows
// at even columns is stored in a 2048 x 16 RAM and reused by the next odd row; the
// buffer is not cleared after reset, so an odd row that follows no even row since reset
// gives undefined colors. Configuration may be written only while the block is idle; a
// frame width of zero acts as one and widths above 4096 act as 4096.
module yuv420_to_rgb888_convert
    import y2r_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FW_W-1:0]      i_cfg_data,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // Fields from bit 0: luma, chroma_first, chroma_second.
    input  wire logic [23:0]          i_s_axis_tdata,
    // Fields from bit 0: frame_start.
    input  wire logic                 i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // Fields from bit 0: red, green, blue.
    output logic [23:0]               o_m_axis_tdata,
    output logic                      o_m_axis_tlast
);

    logic [FW_W-1:0]   r_frame_width;
    logic              r_chroma_order;
    logic [COL_W-1:0]  r_column;
    logic              r_odd_row;
    logic [COL_W-1:0]  n_column;
    logic              n_odd_row;

    logic              r_s1_valid;
    logic [7:0]        r_s1_luma;
    logic              r_s1_wrote;
    logic [15:0]       r_s1_pair;
    logic              r_s1_last;

    logic              r_out_valid;
    logic [23:0]       r_out_data;
    logic              r_out_last;

    logic              advance;
    logic              s_accept;
    logic [FW_W-1:0]   w_eff;
    logic [COL_W-1:0]  cur_col;
    logic              cur_odd;
    logic              cur_last;
    logic              pair_we;
    logic [15:0]       new_pair;
    logic [15:0]       ram_rdata;
    logic [7:0]        pix_red;
    logic [7:0]        pix_green;
    logic [7:0]        pix_blue;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_chroma_order <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                CFG_CHROMA_ORDER: begin
                    r_chroma_order <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = FW_W'(1);
        end else if (r_frame_width > MAX_WIDTH_FW) begin
            w_eff = MAX_WIDTH_FW;
        end else begin
            w_eff = r_frame_width;
        end
        cur_col   = i_s_axis_tuser ? '0 : r_column;
        cur_odd   = i_s_axis_tuser ? 1'b0 : r_odd_row;
        cur_last  = ({1'b0, cur_col} + FW_W'(1)) >= w_eff;
        pair_we   = s_accept && !cur_odd && !cur_col[0];
        new_pair  = r_chroma_order ? {i_s_axis_tdata[15:8], i_s_axis_tdata[23:16]}
                                   : {i_s_axis_tdata[23:16], i_s_axis_tdata[15:8]};
        n_column  = cur_last ? '0 : cur_col + COL_W'(1);
        n_odd_row = cur_last ? !cur_odd : cur_odd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column  <= '0;
            r_odd_row <= 1'b0;
        end else if (s_accept) begin
            r_column  <= n_column;
            r_odd_row <= n_odd_row;
        end
    end

    y2r_ram #(
        .WIDTH (16),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (cur_col[COL_W-1:1]),
        .i_wdata (new_pair),
        .i_re    (s_accept && !pair_we),
        .i_raddr (cur_col[COL_W-1:1]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_luma  <= i_s_axis_tdata[7:0];
            r_s1_wrote <= pair_we;
            r_s1_pair  <= new_pair;
            r_s1_last  <= cur_last;
        end
    end

    always_comb begin
        logic [15:0] pair;
        t_acc c;
        t_acc d;
        t_acc e;
        t_acc yc;
        pair      = r_s1_wrote ? r_s1_pair : ram_rdata;
        c         = t_acc'($signed({1'b0, r_s1_luma} - LUMA_BIAS));
        d         = t_acc'($signed({1'b0, pair[15:8]} - C_OFFSET));
        e         = t_acc'($signed({1'b0, pair[7:0]} - C_OFFSET));
        yc        = K_Y * c + K_ROUND;
        pix_red   = clip_shift(yc + K_RV * e);
        pix_green = clip_shift(yc - K_GU * d - K_GV * e);
        pix_blue  = clip_shift(yc + K_BU * d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_data <= {pix_blue, pix_green, pix_red};
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/core/y2r_checker.sv
`default_nettype none

`include "yuv420_to_rgb888_convert_defines.svh"

module y2r_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    // A stalled result keeps its request up.
    `Y2R_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

    // A stalled result keeps its payload.
    `Y2R_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // The input side only stalls when both internal stages are full.
    `Y2R_ASSERT_SAME(a_in_stall, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready)

    // A taken request passes the input and output registers and shows up as a result if the output side is free.
    `Y2R_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) ##1 i_m_axis_tready, o_m_axis_tvalid)

endmodule

bind yuv420_to_rgb888_convert y2r_checker u_y2r_checker (.*);

`default_nettype wire
